// ===== hdl/rms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_pkg: shared definitions for the running median block
// Sizes, payload types, the link between neighboring cells and the control
// states of the sequencer.
// ----------------------------------------------------------------------------
package rms_pkg;

    localparam int CAPACITY     = 256;
    localparam int SAMPLE_WIDTH = 32;
    localparam int COUNT_W      = $clog2(CAPACITY + 1);
    localparam int MEDIAN_W     = SAMPLE_WIDTH + 1;
    localparam int GROUP        = 16;
    localparam int NUM_GROUPS   = (CAPACITY + GROUP - 1) / GROUP;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic        [COUNT_W-1:0]      t_count;
    typedef logic signed [MEDIAN_W-1:0]     t_median;

    typedef struct packed {
        logic    after;
        t_sample value;
    } t_link;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SELECT,
        ST_REDUCE,
        ST_SUM
    } t_state;

endpackage

// ===== hdl/rms_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_if: channel interfaces of the running median block
// Sample input channel and median result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rms_in_if;
    logic             valid;
    logic             ready;
    rms_pkg::t_sample sample;
    logic             restart;

    modport source(output valid, sample, restart, input ready);
    modport sink(input valid, sample, restart, output ready);
endinterface

interface rms_out_if;
    logic             valid;
    logic             ready;
    rms_pkg::t_median median_doubled;
    rms_pkg::t_count  held_count;
    logic             overflow;

    modport source(output valid, median_doubled, held_count, overflow, input ready);
    modport sink(input valid, median_doubled, held_count, overflow, output ready);
endinterface

// ===== hdl/rms_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_cell: one entry of the sorted chain
// Holds one sample. On an insert it keeps its value, takes the new sample,
// or takes the value of its left neighbor, so the chain stays in order.
// ----------------------------------------------------------------------------
module rms_cell (
    input  logic             i_clk,
    input  logic             i_ins,
    input  logic             i_valid,
    input  rms_pkg::t_sample i_x,
    input  rms_pkg::t_link   i_link,
    output rms_pkg::t_link   o_link
);
    import rms_pkg::*;

    t_sample r_value;
    t_sample n_value;
    logic    after;

    // A cell lies after the insertion point when it is empty or holds a
    // larger value; equal values stay in front of the new sample.
    assign after = !i_valid || (r_value > i_x);

    always_comb begin
        if (after) begin
            n_value = i_link.after ? i_link.value : i_x;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ins) begin
            r_value <= n_value;
        end
    end

    assign o_link.after = after;
    assign o_link.value = r_value;

endmodule

// ===== hdl/rms_pick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_pick: middle element select
// Picks the lower and upper middle entries of the chain through a two-level
// registered select tree; the results come from its second register level,
// which follows the group register level, after the chain and count settle.
// ----------------------------------------------------------------------------
module rms_pick (
    input  logic             i_clk,
    input  rms_pkg::t_sample i_values [rms_pkg::CAPACITY],
    input  rms_pkg::t_count  i_count,
    output rms_pkg::t_sample o_lo,
    output rms_pkg::t_sample o_hi
);
    import rms_pkg::*;

    t_count  mid;
    t_count  lo_idx;
    t_sample n_lo_part [NUM_GROUPS];
    t_sample n_hi_part [NUM_GROUPS];
    t_sample r_lo_part [NUM_GROUPS];
    t_sample r_hi_part [NUM_GROUPS];
    t_sample n_lo;
    t_sample n_hi;
    t_sample r_lo;
    t_sample r_hi;

    assign mid    = i_count >> 1;
    assign lo_idx = i_count[0] ? mid : t_count'(mid - 1'b1);

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_lo_part[g] = '0;
            n_hi_part[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                if (g * GROUP + j < CAPACITY) begin
                    if (t_count'(g * GROUP + j) == lo_idx) begin
                        n_lo_part[g] = n_lo_part[g] | i_values[g * GROUP + j];
                    end
                    if (t_count'(g * GROUP + j) == mid) begin
                        n_hi_part[g] = n_hi_part[g] | i_values[g * GROUP + j];
                    end
                end
            end
        end
    end

    always_comb begin
        n_lo = '0;
        n_hi = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_lo = n_lo | r_lo_part[g];
            n_hi = n_hi | r_hi_part[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo_part <= n_lo_part;
        r_hi_part <= n_hi_part;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

// ===== hdl/running_median_sorted_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_sorted_store: running median over a sorted chain
// Keeps every sample of the current run in order and reports twice the
// median after each sample.
// ----------------------------------------------------------------------------
// Each accepted sample is inserted into all 256 cells of the sorted chain in
// the transfer cycle itself; the lower and upper middle entries then pass a
// two-level registered select tree and one 33-bit adder, in the states
// SELECT, REDUCE and SUM; the block takes no new sample until that result
// is loaded, which waits while the previous result is still untaken. A finished
// result waits in the output register without holding up the next sample.
// The chain needs no clearing after reset: only entries below the held
// count are ever selected. A restart empties the store before its sample;
// a sample arriving at a full store is dropped, flagged with overflow, and
// the median of the unchanged store is reported.
// ----------------------------------------------------------------------------
module running_median_sorted_store (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rms_in_if.sink    i_in,
    rms_out_if.source o_out
);
    import rms_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_count  r_count;
    t_count  n_count;
    t_count  eff_count;
    logic    r_drop;
    logic    full;
    logic    accept;
    logic    ins;
    logic    load;
    logic    r_out_valid;
    t_median r_median;
    t_count  r_held;
    logic    r_ovf;
    t_sample lo;
    t_sample hi;
    t_median sum;
    logic    cell_valid [CAPACITY];
    t_link   link [CAPACITY+1];
    t_sample values [CAPACITY];

    assign accept    = i_in.valid && i_in.ready;
    assign eff_count = i_in.restart ? '0 : r_count;
    assign full      = eff_count >= t_count'(CAPACITY);
    assign ins       = accept && !full;
    assign n_count   = full ? eff_count : t_count'(eff_count + 1'b1);

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_valid[i] = t_count'(i) < eff_count;
        end
    end

    assign link[0].after = 1'b0;
    assign link[0].value = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        rms_cell u_cell (
            .i_clk   (i_clk),
            .i_ins   (ins),
            .i_valid (cell_valid[i]),
            .i_x     (i_in.sample),
            .i_link  (link[i]),
            .o_link  (link[i+1])
        );
        assign values[i] = link[i+1].value;
    end

    rms_pick u_pick (
        .i_clk    (i_clk),
        .i_values (values),
        .i_count  (r_count),
        .o_lo     (lo),
        .o_hi     (hi)
    );

    assign sum  = t_median'({lo[SAMPLE_WIDTH-1], lo}) + t_median'({hi[SAMPLE_WIDTH-1], hi});
    assign load = (r_state == ST_SUM) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_state = ST_SELECT;
                end
            end
            ST_SELECT: begin
                n_state = ST_REDUCE;
            end
            ST_REDUCE: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count <= n_count;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drop <= full;
        end
        if (load) begin
            r_median <= sum;
            r_held   <= r_count;
            r_ovf    <= r_drop;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.median_doubled = r_median;
    assign o_out.held_count     = r_held;
    assign o_out.overflow       = r_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("held count exceeds capacity");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_SELECT))
        else $error("transfer did not start the select sequence");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_in.restart && (r_count < t_count'(CAPACITY)))
        |=> (r_count == t_count'($past(r_count) + 1'b1)))
        else $error("held count did not advance on insert");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_SUM))
        else $error("result appeared outside the sum step");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ovf) |-> (r_held == t_count'(CAPACITY)))
        else $error("overflow reported with a store that is not full");

endmodule

// ===== dv/tb_running_median_sorted_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_median_sorted_store: self-checking bench for the running median
// Drives signed samples with restart flags through the input channel, keeps
// its own sorted copy of every run to predict twice the median, the held
// count and the drop flag, and checks each result transfer in order. Both
// channels idle in random bursts, and one long receiver hold-off backs the
// block up into its input.
// ----------------------------------------------------------------------------
module tb_running_median_sorted_store;
    import rms_pkg::*;

    localparam int      NUM_RANDOM    = 800;
    localparam int      QUIET_TAIL    = 100;
    localparam int      STALL_LIMIT   = 2000;
    localparam int      HOLDOFF_LEN   = 120;
    localparam int      REPORT_LIMIT  = 10;
    localparam t_sample SAMPLE_MAX    = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam t_sample SAMPLE_MIN    = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    typedef struct {
        t_median median_doubled;
        t_count  held_count;
        logic    overflow;
    } t_median_result;

    class median_tracker;
        t_sample        sorted_run[$];
        t_median_result expected_medians[$];
        int             failures;
        int             checked;
        int             dropped;
        int             restarts;
        int             peak_count;

        function void note_sample(t_sample s, logic restart);
            t_median_result r;
            int             pos;
            int             n;
            if (restart) begin
                sorted_run.delete();
                restarts++;
            end
            r.overflow = (sorted_run.size() >= CAPACITY);
            if (!r.overflow) begin
                pos = 0;
                while (pos < sorted_run.size() && sorted_run[pos] <= s) pos++;
                sorted_run.insert(pos, s);
            end else begin
                dropped++;
            end
            n = sorted_run.size();
            if (n > peak_count) peak_count = n;
            r.held_count = t_count'(n);
            if (n % 2 == 1) begin
                r.median_doubled = t_median'(sorted_run[n / 2]) + t_median'(sorted_run[n / 2]);
            end else begin
                r.median_doubled = t_median'(sorted_run[n / 2 - 1])
                                 + t_median'(sorted_run[n / 2]);
            end
            expected_medians.insert(expected_medians.size(), r);
        endfunction

        function void check_result(t_median median_doubled, t_count held_count, logic overflow);
            t_median_result want;
            checked++;
            if (expected_medians.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("%t: result with no sample pending: median2=%0d count=%0d ovf=%0b",
                             $realtime, median_doubled, held_count, overflow);
                end
                return;
            end
            want = expected_medians.pop_front();
            if (want.median_doubled !== median_doubled || want.held_count !== held_count
                    || want.overflow !== overflow) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("%t: result %0d mismatch: expected median2=%0d count=%0d ovf=%0b,",
                             $realtime, checked, want.median_doubled, want.held_count,
                             want.overflow);
                    $display("    got median2=%0d count=%0d ovf=%0b",
                             median_doubled, held_count, overflow);
                end
            end
        endfunction

        function int pending();
            return expected_medians.size();
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    bit            quiet;
    int            stall_cycles;
    int            samples_sent;
    median_tracker tracker;

    rms_in_if  in_ch();
    rms_out_if out_ch();

    running_median_sorted_store dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_sample(input t_sample s, input logic restart);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= s;
        in_ch.restart <= restart;
        @(posedge clk);
        while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
        tracker.note_sample(s, restart);
        samples_sent++;
        @(negedge clk);
    endtask

    function automatic t_sample pick_sample(input t_sample previous);
        case ($urandom_range(0, 11))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return previous;
            3:       return t_sample'(int'($urandom_range(0, 8)) - 4);
            default: return t_sample'($urandom);
        endcase
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            tracker.check_result(out_ch.median_doubled, out_ch.held_count, out_ch.overflow);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d cycles without a transfer.", stall_cycles);
                $display("Verification failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        int  len;
        bit  held_off;
        out_ch.ready = 1'b0;
        held_off     = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (quiet) begin
                out_ch.ready <= 1'b1;
                len = 1;
            end else if (!held_off && tracker.checked >= 40) begin
                out_ch.ready <= 1'b0;
                len = HOLDOFF_LEN;
                held_off = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                len = $urandom_range(1, 11);
            end else begin
                out_ch.ready <= 1'b1;
                len = $urandom_range(1, 24);
            end
            repeat (len) @(negedge clk);
        end
    end

    initial begin
        int      random_left;
        int      run_len;
        bit      first_run;
        t_sample s;
        t_sample previous;
        tracker       = new();
        quiet         = 1'b0;
        stall_cycles  = 0;
        samples_sent  = 0;
        in_ch.valid   = 1'b0;
        in_ch.sample  = '0;
        in_ch.restart = 1'b0;
        rst_n         = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes, equal values and restarts.
        send_sample('0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(-1, 1'b1);
        send_sample(1, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(1, 1'b0);
        send_sample('0, 1'b0);
        send_sample(5, 1'b1);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(t_sample'(32'h5555_5555), 1'b1);
        send_sample(t_sample'(32'hAAAA_AAAA), 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);

        // Runs of random length; long ones overfill the store, and the run
        // after one of them restarts while the store is full.
        random_left = NUM_RANDOM;
        first_run   = 1'b1;
        previous    = '0;
        while (random_left > 0) begin
            if (first_run || $urandom_range(0, 7) == 0) begin
                run_len = $urandom_range(CAPACITY + 2, CAPACITY + 19);
            end else begin
                run_len = $urandom_range(1, 40);
            end
            first_run = 1'b0;
            for (int k = 0; k < run_len && random_left > 0; k++) begin
                quiet = (random_left <= QUIET_TAIL);
                s = pick_sample(previous);
                send_sample(s, (k == 0) || ($urandom_range(0, 63) == 0));
                previous = s;
                random_left--;
            end
        end
        in_ch.valid <= 1'b0;

        while (tracker.pending() != 0) @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Sent %0d samples with %0d restarts; %0d dropped at a full store, largest %0d.",
                 samples_sent, tracker.restarts, tracker.dropped, tracker.peak_count);
        $display("Checked %0d result transfers, %0d failures.", tracker.checked, tracker.failures);
        if (tracker.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
